@@ src/tte_pkg.sv @@
`timescale 1ns / 1ps
package tte_pkg;

	// command codes
	localparam logic [2:0] CMD_REGISTER = 3'd0;
	localparam logic [2:0] CMD_ENTER    = 3'd1;
	localparam logic [2:0] CMD_EXIT     = 3'd2;
	localparam logic [2:0] CMD_TICK     = 3'd3;
	localparam logic [2:0] CMD_INIT     = 3'd4;

	// packet types
	localparam logic [1:0] PKT_NAME  = 2'd0;
	localparam logic [1:0] PKT_TICK  = 2'd3;

	// task ids
	localparam int         ID_W           = 4;
	localparam logic [3:0] FULL_ID        = 4'd15;
	localparam int         TTE_TASK_SLOTS = 15;

	// time handling
	localparam logic [31:0] DELTA_MAX      = 32'h0000_0FFF;
	localparam logic [31:0] TICK_GAP_RESET = 32'd2000;

	// name packing
	localparam int         NAME_CHARS   = 5;
	localparam int         CODE_W       = 5;
	localparam int         NAME_W       = NAME_CHARS * CODE_W;
	localparam int         ID_SHIFT_NAME = 25;
	localparam int         ID_SHIFT_TIME = 12;
	localparam logic [4:0] CODE_SPACE   = 5'd27;
	localparam logic [4:0] CODE_DASH    = 5'd28;
	localparam logic [4:0] CODE_USCORE  = 5'd29;
	localparam logic [4:0] CODE_OTHER   = 5'd31;

	// configuration register indexes
	localparam logic REG_IDLE_HANDLE = 1'b0;
	localparam logic REG_TICK_GAP    = 1'b1;

	// result of a handle lookup
	typedef struct packed {
		logic             hit;
		logic             full;
		logic [ID_W-1:0]  id;
	} lookup_t;

	// 5-bit code of one name character
	function automatic logic [CODE_W-1:0] letter_code(input logic [7:0] c);
		logic [CODE_W-1:0] code;
		priority if (c >= 8'h41 && c <= 8'h5A) begin
			code = CODE_W'(c - 8'h40);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			code = CODE_W'(c - 8'h60);
		end else if (c == 8'h20) begin
			code = CODE_SPACE;
		end else if (c == 8'h2D) begin
			code = CODE_DASH;
		end else if (c == 8'h5F) begin
			code = CODE_USCORE;
		end else begin
			code = CODE_OTHER;
		end
		return code;
	endfunction

endpackage

@@ src/tte_name_pack.sv @@
`timescale 1ns / 1ps
module tte_name_pack
	import tte_pkg::*;
(
	input  logic [7:0]        name_char0,
	input  logic [7:0]        name_char1,
	input  logic [7:0]        name_char2,
	input  logic [7:0]        name_char3,
	input  logic [7:0]        name_char4,
	output logic [NAME_W-1:0] name_code
);

	logic [7:0] chars [NAME_CHARS];
	logic [NAME_CHARS-1:0] live;

	assign chars[0] = name_char0;
	assign chars[1] = name_char1;
	assign chars[2] = name_char2;
	assign chars[3] = name_char3;
	assign chars[4] = name_char4;

	// a character counts only while no zero byte came before it
	always_comb begin
		for (int i = 0; i < NAME_CHARS; i++) begin
			if (i == 0) begin
				live[i] = (chars[i] != 8'h00);
			end else begin
				live[i] = live[i-1] && (chars[i] != 8'h00);
			end
			name_code[i*CODE_W +: CODE_W] = live[i] ? letter_code(chars[i]) : '0;
		end
	end

endmodule

@@ src/tte_handle_table.sv @@
`timescale 1ns / 1ps
module tte_handle_table
	import tte_pkg::*;
#(
	parameter int TASK_SLOTS = TTE_TASK_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] handle,
	input  logic        alloc,
	input  logic        clear,
	output lookup_t     lookup
);

	logic [31:0]           entry_q [TASK_SLOTS];
	logic [ID_W-1:0]       count_q;
	logic [TASK_SLOTS-1:0] match;
	logic [ID_W-1:0]       hit_id;

	// parallel compare against the filled entries
	always_comb begin
		for (int i = 0; i < TASK_SLOTS; i++) begin
			match[i] = (ID_W'(i) < count_q) && (entry_q[i] == handle);
		end
	end

	// lowest matching slot wins
	always_comb begin
		hit_id = '0;
		for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_id = ID_W'(i);
			end
		end
	end

	always_comb begin
		lookup.hit  = |match;
		lookup.full = (count_q == ID_W'(TASK_SLOTS));
		if (lookup.hit) begin
			lookup.id = hit_id;
		end else if (lookup.full) begin
			lookup.id = FULL_ID;
		end else begin
			lookup.id = count_q;
		end
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clear) begin
			count_q <= '0;
		end else if (alloc && !lookup.hit && !lookup.full) begin
			count_q <= count_q + 1'b1;
		end
	end

	// new handle goes into the next free slot
	always_ff @(posedge clk) begin
		for (int i = 0; i < TASK_SLOTS; i++) begin
			if (alloc && !clear && !lookup.hit && !lookup.full && count_q == ID_W'(i)) begin
				entry_q[i] <= handle;
			end
		end
	end

endmodule

@@ src/task_trace_packet_encoder.sv @@
`timescale 1ns / 1ps
// an accepted event goes to the input register, then its packet to the output register
// throughput: one event per cycle unless the output is stalled; the handle compare,
// time delta and state update of one event all settle within the single processing stage
// reset: task count and last packet time clear to zero, idle handle to zero, tick gap
// to 2000; handle table contents stay undefined until written, no clearing pass
module task_trace_packet_encoder
	import tte_pkg::*;
#(
	parameter int TASK_SLOTS = TTE_TASK_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	// event channel
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [2:0]  cmd,
	input  logic [31:0] event_handle,
	input  logic [7:0]  name_char0,
	input  logic [7:0]  name_char1,
	input  logic [7:0]  name_char2,
	input  logic [7:0]  name_char3,
	input  logic [7:0]  name_char4,
	input  logic [31:0] now_us,
	// packet channel
	output logic        pkt_valid,
	input  logic        pkt_stall,
	output logic [1:0]  packet_type,
	output logic [31:0] payload,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [31:0] idle_handle_q;
	logic [31:0] tick_gap_q;
	logic [31:0] last_time_q;

	logic        valid_s1;
	logic [2:0]  cmd_s1;
	logic [31:0] handle_s1;
	logic [7:0]  char0_s1, char1_s1, char2_s1, char3_s1, char4_s1;
	logic [31:0] now_s1;

	logic        pkt_valid_q;
	logic [1:0]  packet_type_q;
	logic [31:0] payload_q;

	logic              advance;
	logic              item_accept;
	logic [NAME_W-1:0] name_code;
	lookup_t           lookup;
	logic              is_idle;
	logic              alloc;
	logic              clear;
	logic [31:0]       delta;
	logic [11:0]       delta_sat;
	logic              emit;
	logic              touch_time;
	logic [31:0]       result;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TICK_GAP) ? tick_gap_q : idle_handle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_handle_q <= '0;
			tick_gap_q    <= TICK_GAP_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_IDLE_HANDLE) begin
				idle_handle_q <= pwdata;
			end else begin
				tick_gap_q <= pwdata;
			end
		end
	end

	// handshake
	assign advance     = valid_s1 && (!pkt_valid_q || !pkt_stall);
	assign item_stall  = valid_s1 && !advance;
	assign item_accept = item_valid && !item_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			cmd_s1    <= cmd;
			handle_s1 <= event_handle;
			char0_s1  <= name_char0;
			char1_s1  <= name_char1;
			char2_s1  <= name_char2;
			char3_s1  <= name_char3;
			char4_s1  <= name_char4;
			now_s1    <= now_us;
		end
	end

	tte_name_pack u_name_pack (
		.name_char0 (char0_s1),
		.name_char1 (char1_s1),
		.name_char2 (char2_s1),
		.name_char3 (char3_s1),
		.name_char4 (char4_s1),
		.name_code  (name_code)
	);

	// table lookup, allocating on register and on non-idle enter or exit
	assign is_idle = (handle_s1 == idle_handle_q);
	assign alloc   = advance && ((cmd_s1 == CMD_REGISTER) ||
		(((cmd_s1 == CMD_ENTER) || (cmd_s1 == CMD_EXIT)) && !is_idle));
	assign clear   = advance && (cmd_s1 == CMD_INIT);

	tte_handle_table #(
		.TASK_SLOTS (TASK_SLOTS)
	) u_handle_table (
		.clk    (clk),
		.arst_n (arst_n),
		.handle (handle_s1),
		.alloc  (alloc),
		.clear  (clear),
		.lookup (lookup)
	);

	// time delta with saturation
	assign delta     = now_s1 - last_time_q;
	assign delta_sat = (delta > DELTA_MAX) ? DELTA_MAX[11:0] : delta[11:0];

	// per-command decision
	always_comb begin
		emit       = 1'b0;
		touch_time = 1'b0;
		result     = '0;
		unique case (cmd_s1)
			CMD_REGISTER: begin
				emit   = (lookup.id != FULL_ID);
				result = (32'(lookup.id) << ID_SHIFT_NAME) | 32'(name_code);
			end
			CMD_ENTER, CMD_EXIT: begin
				emit       = !is_idle;
				touch_time = !is_idle;
				result     = (32'(lookup.id) << ID_SHIFT_TIME) | 32'(delta_sat);
			end
			CMD_TICK: begin
				emit       = (delta > tick_gap_q);
				touch_time = emit;
				result     = 32'(delta_sat);
			end
			CMD_INIT: begin
				touch_time = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// last packet time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
		end else if (advance && touch_time) begin
			last_time_q <= now_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_valid_q <= 1'b0;
		end else if (advance) begin
			pkt_valid_q <= emit;
		end else if (!pkt_stall) begin
			pkt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			packet_type_q <= (cmd_s1 == CMD_REGISTER) ? PKT_NAME :
				(cmd_s1 == CMD_TICK) ? PKT_TICK : cmd_s1[1:0];
			payload_q     <= result;
		end
	end

	assign pkt_valid   = pkt_valid_q;
	assign packet_type = packet_type_q;
	assign payload     = payload_q;

endmodule
